>>> rtl/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg
// Shared constants, codes and types for the ordered list core.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_DISPLAY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  entry_value;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [VAL_W-1:0]  wdata;
    logic [IDX_W-1:0]         raddr;
  } ram_req_t;

endpackage

>>> rtl/olad_ram.sv
// ----------------------------------------------------------------------------
// olad_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module olad_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/olad_obuf.sv
// ----------------------------------------------------------------------------
// olad_obuf
// One-entry result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module olad_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  olad_pkg::res_t res,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output olad_pkg::res_t out_res
);
  import olad_pkg::*;

  logic valid_r;
  res_t data_r;

  // accept a new result when empty or when the held one leaves this cycle
  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

endmodule

>>> rtl/olad_seq.sv
// ----------------------------------------------------------------------------
// olad_seq
// Request sequencer: append, search and shift for delete, display walk.
// ----------------------------------------------------------------------------
module olad_seq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_req,
  input  logic signed [olad_pkg::VAL_W-1:0]       in_value,
  input  logic                                    out_space,
  output logic                                    out_push,
  output olad_pkg::res_t                          out_res,
  output olad_pkg::ram_req_t                      ram,
  input  logic signed [olad_pkg::VAL_W-1:0]       ram_rdata
);
  import olad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHIFT,
    S_DISP,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  res_t                    res_r, res_nxt;
  logic                    at_last;
  logic [IDX_W-1:0]        idx_inc;

  function automatic res_t mk_res(status_t st);
    res_t r;
    r.status      = st;
    r.entry_value = '0;
    r.last        = 1'b1;
    return r;
  endfunction

  assign at_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign idx_inc  = idx_r + IDX_W'(1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    ram.we    = 1'b0;
    ram.waddr = cnt_r[IDX_W-1:0];
    ram.wdata = in_value;
    ram.raddr = idx_r;
    out_push  = 1'b0;
    out_res   = res_r;
    unique case (state_r)
      S_IDLE: begin
        ram.raddr = '0;
        if (in_valid) begin
          val_nxt = in_value;
          idx_nxt = '0;
          case (in_req)
            REQ_APPEND: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_nxt = mk_res(ST_FULL);
              end else begin
                ram.we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                res_nxt = mk_res(ST_OK);
              end
              state_nxt = S_RESP;
            end
            REQ_DELETE: begin
              if (cnt_r == '0) begin
                res_nxt   = mk_res(ST_EMPTY);
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            REQ_DISPLAY: begin
              if (cnt_r == '0) begin
                res_nxt   = mk_res(ST_EMPTY);
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DISP;
              end
            end
            default: begin
              // unused code: drop the item
            end
          endcase
        end
      end
      S_SRCH: begin
        if (ram_rdata == val_r) begin
          if (at_last) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            res_nxt   = mk_res(ST_OK);
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = idx_inc;
            ram.raddr = idx_inc;
            state_nxt = S_SHIFT;
          end
        end else if (at_last) begin
          res_nxt   = mk_res(ST_NOT_FOUND);
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_inc;
          ram.raddr = idx_inc;
        end
      end
      S_SHIFT: begin
        // move entry idx down one place while the next one is read
        ram.we    = 1'b1;
        ram.waddr = idx_r - IDX_W'(1);
        ram.wdata = ram_rdata;
        if (at_last) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          res_nxt   = mk_res(ST_OK);
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_inc;
          ram.raddr = idx_inc;
        end
      end
      S_DISP: begin
        // hold the read address while stalled so the read data repeats
        out_res.status      = ST_OK;
        out_res.entry_value = ram_rdata;
        out_res.last        = at_last;
        if (out_space) begin
          out_push = 1'b1;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            ram.raddr = idx_inc;
          end
        end
      end
      S_RESP: begin
        if (out_space) begin
          out_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> out_space)
    else $error("result pushed into a full output register");

  a_disp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |-> !ram.we)
    else $error("store written during display");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_req == REQ_APPEND && cnt_r < CNT_W'(DEPTH))
    |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("append did not advance the count");

endmodule

>>> rtl/ordered_list_append_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_core
// Ordered list of up to DEPTH signed 32-bit entries with append, delete and
// display requests, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Operation: an append result enters the output register from the response
//   state once that register has space; a delete searches from the oldest
//   entry, then shifts the later entries down one place; a display loads its
//   first entry after a RAM read, then one a cycle while the result channel
//   is ready. Throughput: one request at a time; the next item is taken once
//   the last result of the current one has entered the output register.
// Reset: synchronous, active low; clears the entry count and control state.
//   The entry RAM is not cleared; entries at or beyond the count are never used.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] entry_value
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);
  import olad_pkg::*;

  ram_req_t                ram;
  logic signed [VAL_W-1:0] ram_rdata;
  logic                    push;
  logic                    space;
  res_t                    seq_res;
  res_t                    obuf_res;

  // Sequencer: one request at a time; walks one entry/cycle unless output full.
  olad_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_value  (in_tdata),
    .out_space (space),
    .out_push  (push),
    .out_res   (seq_res),
    .ram       (ram),
    .ram_rdata (ram_rdata)
  );

  // Entry store, oldest entry at address zero.
  olad_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  // Result register: hold an item until the result channel takes it.
  olad_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (seq_res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (obuf_res)
  );

  assign out_tdata = obuf_res.entry_value;
  assign out_tuser = obuf_res.status;
  assign out_tlast = obuf_res.last;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list core. A queue of requests is
// built up front: a directed opening that covers the empty, full, no-match,
// duplicate and ignored-code cases, then random runs of appends, deletes and
// displays over a small pool of values. A shadow list predicts every result
// when a request is accepted, and the result channel is compared against it.
// Both channels idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olad_pkg::*;

  // unused request code, dropped by the block without a result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 240;  // counted requests in the random part
  localparam int TAIL_ITEMS   = 40;   // closing stretch with no idling
  localparam int QUIET_LIMIT  = 2000; // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    logic [1:0]       code;
    logic [VAL_W-1:0] value;
  } list_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  list_req_t req_queue[$];      // requests not yet presented
  res_t      due_results[$];    // predicted results, oldest first

  // shadow copy of the list
  logic [VAL_W-1:0] list_mem [DEPTH];
  int               list_count = 0;

  int  error_count = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  hold_gap = 0;
  logic [VAL_W-1:0] pool [POOL_SIZE];

  ordered_list_append_delete_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow list
  // --------------------------------------------------------------------------
  function automatic void expect_result(status_t status, logic [VAL_W-1:0] value,
                                        logic last);
    res_t r;
    r.status      = status;
    r.entry_value = value;
    r.last        = last;
    due_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue what it causes.
  function automatic void apply_list_op(logic [1:0] code, logic [VAL_W-1:0] value);
    int hit;
    hit = -1;
    case (code)
      REQ_APPEND: begin
        if (list_count >= DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          list_mem[list_count] = value;
          list_count++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (list_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // first match counted from the oldest entry
          for (int i = 0; i < list_count; i++) begin
            if (hit < 0 && list_mem[i] == value) hit = i;
          end
          if (hit < 0) begin
            expect_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            // close the gap, keeping order
            for (int i = hit; i + 1 < list_count; i++) list_mem[i] = list_mem[i + 1];
            list_count--;
            expect_result(ST_OK, '0, 1'b1);
          end
        end
      end
      REQ_DISPLAY: begin
        if (list_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_count; i++)
            expect_result(ST_OK, list_mem[i], (i == list_count - 1));
        end
      end
      default: ; // unused code: no result, no change
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_req(logic [1:0] code, logic [VAL_W-1:0] value);
    list_req_t it;
    it.code  = code;
    it.value = value;
    req_queue.push_back(it);
  endfunction

  // Mostly pool values so that deletes hit and duplicates appear.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: present queued items, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_req_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_list_op(in_tuser, in_tdata);
      // load the next item only once the bus is free
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (req_queue.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          in_tvalid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          it = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= it.code;
          in_tdata  <= it.value;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: stall at random, compare each item with the oldest
  // prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result status %0d value %h last %b",
                   $realtime, out_tuser, out_tdata, out_tlast);
          error_count++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_tuser !== exp_r.status || out_tdata !== exp_r.entry_value ||
              out_tlast !== exp_r.last) begin
            $display({"%0t: mismatch expected status %0d value %h last %b, ",
                      "actual status %0d value %h last %b"},
                     $realtime, exp_r.status, exp_r.entry_value, exp_r.last,
                     out_tuser, out_tdata, out_tlast);
            error_count++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_tready <= 1'b0;
      end else if (req_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
        hold_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [VAL_W-1:0] fill [DEPTH];
    int counted;
    int run_len;
    int kind;

    // directed opening: empty list cases and the ignored code
    queue_req(REQ_DISPLAY, 32'h0000_0000);
    queue_req(REQ_DELETE,  32'h8000_0000);
    queue_req(REQ_UNUSED,  32'hFFFF_FFFF);
    // fill to capacity with extremes and a duplicate
    for (int i = 0; i < DEPTH; i++) fill[i] = $urandom();
    fill[0]         = 32'h8000_0000;
    fill[1]         = 32'h7FFF_FFFF;
    fill[2]         = 32'h0000_0000;
    fill[3]         = 32'hFFFF_FFFF;
    fill[4]         = 32'h7FFF_FFFF;
    fill[DEPTH - 1] = 32'h5555_AAAA;
    for (int i = 0; i < DEPTH; i++) queue_req(REQ_APPEND, fill[i]);
    queue_req(REQ_APPEND,  32'hAAAA_5555);   // refused: list full
    queue_req(REQ_DISPLAY, 32'hFFFF_FFFF);   // full display
    queue_req(REQ_DELETE,  32'h1357_9BDF);   // no match
    queue_req(REQ_DELETE,  32'h7FFF_FFFF);   // first of two duplicates
    queue_req(REQ_DELETE,  32'h8000_0000);   // oldest entry
    queue_req(REQ_DELETE,  32'h5555_AAAA);   // newest entry
    queue_req(REQ_DISPLAY, 32'h0000_0000);

    // random part: runs that fill, drain or mix over a small value pool
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom();
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // refresh one pool entry now and then
      if ($urandom_range(0, 3) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
      kind    = $urandom_range(0, 2);
      run_len = $urandom_range(2, 20);
      for (int j = 0; j < run_len; j++) begin
        if ($urandom_range(0, 29) == 0) begin
          queue_req(REQ_UNUSED, $urandom());  // noise, not counted
        end else begin
          if ($urandom_range(0, 7) == 0) queue_req(REQ_DISPLAY, $urandom());
          else if (kind == 0) queue_req(REQ_APPEND, pick_value());
          else if (kind == 1) queue_req(REQ_DELETE, pick_value());
          else if ($urandom_range(0, 1) == 0) queue_req(REQ_APPEND, pick_value());
          else queue_req(REQ_DELETE, pick_value());
          counted++;
        end
      end
    end
    queue_req(REQ_DISPLAY, 32'h0000_0000);

    // reset once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // hold until every item is accepted and every result has arrived
    while (req_queue.size() > 0 || in_tvalid || due_results.size() > 0) @(posedge clk);
    // let a trailing ignored request or stray result surface
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
